@@ design/mesfb_pkg.sv @@
package mesfb_pkg;

    // Field widths of the sample and feedback words.
    localparam int ENC_W    = 13;
    localparam int RPM_W    = 16;
    localparam int SPEED_W  = 24;
    localparam int TURN_W   = 6;
    localparam int ANGLE_W  = 20;
    localparam int SGAIN_W  = 24;
    localparam int AGAIN_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAIN = 1'b1;

    localparam logic [SGAIN_W-1:0] SGAIN_RST = 24'd48803;
    localparam logic [AGAIN_W-1:0] AGAIN_RST = 32'd57211;

    // Defaults of the top level parameters.
    localparam int TURN_WRAP_DEF      = 18;
    localparam int ENCODER_SPAN_DEF   = 8191;
    localparam int JUMP_THRESHOLD_DEF = 4096;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 48;

    // Filter coefficients, Q2.16.
    localparam logic signed [MUL_A_W-1:0] C_NEWER = 34'sd113096;
    localparam logic signed [MUL_A_W-1:0] C_OLDER = -34'sd49542;
    localparam logic signed [MUL_B_W-1:0] C_INPUT = 25'sd1982;

    localparam int SPEED_MAX = 8388607;
    localparam int SPEED_MIN = -8388608;
    localparam int ANGLE_MAX = 524287;
    localparam int ANGLE_MIN = -524288;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RPM   = 9'b000000010,
        ST_NEWER = 9'b000000100,
        ST_OLDER = 9'b000001000,
        ST_INPUT = 9'b000010000,
        ST_SPAN  = 9'b000100000,
        ST_OFFS  = 9'b001000000,
        ST_ANGLE = 9'b010000000,
        ST_DONE  = 9'b100000000
    } t_state;

endpackage

@@ design/mesfb_in_if.sv @@
interface mesfb_in_if import mesfb_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ENC_W-1:0]         encoder_now;
    logic [ENC_W-1:0]         encoder_before;
    logic signed [RPM_W-1:0]  rotor_rpm;

    modport source (output valid, encoder_now, encoder_before, rotor_rpm, input ready);
    modport sink   (input valid, encoder_now, encoder_before, rotor_rpm, output ready);
endinterface

@@ design/mesfb_out_if.sv @@
interface mesfb_out_if import mesfb_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SPEED_W-1:0]  filtered_speed;
    logic signed [TURN_W-1:0]   turn_count;
    logic signed [ANGLE_W-1:0]  output_angle;

    modport source (output valid, filtered_speed, turn_count, output_angle, input ready);
    modport sink   (input valid, filtered_speed, turn_count, output_angle, output ready);
endinterface

@@ design/mesfb_mul.sv @@
module mesfb_mul import mesfb_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [MUL_A_W-1:0]  i_a,
    input  logic signed [MUL_B_W-1:0]  i_b,
    output logic signed [PROD_W-1:0]   o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Signed product, registered before any use.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

@@ design/motor_encoder_speed_feedback.sv @@
// Channel   Dir  Handshake     Word contents
// i_samp    in   valid/ready   encoder_now, encoder_before, rotor_rpm
// o_fb      out  valid/ready   filtered_speed, turn_count, output_angle
// i_cfg_*   in   write enable  register index, 32-bit write data
//
// Each sample word runs through eight sequencer steps from acceptance to a valid
// feedback word, and these steps share the single registered multiplier.
// A new sample is accepted once the sequencer is back in idle, which it enters as the
// result is written, even while that result still waits in the output register.
// Reset is synchronous and active low; it clears the filter history, the turn count,
// both gains to their defaults and all valid flags.
// A stalled output holds the sequencer in its last step until the word is taken.
module motor_encoder_speed_feedback import mesfb_pkg::*; #(
    parameter int TURN_WRAP      = TURN_WRAP_DEF,
    parameter int ENCODER_SPAN   = ENCODER_SPAN_DEF,
    parameter int JUMP_THRESHOLD = JUMP_THRESHOLD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    mesfb_in_if.sink              i_samp,
    mesfb_out_if.source           o_fb
);

    // Sequencer and configuration registers.
    t_state                     r_state, n_state;
    logic [SGAIN_W-1:0]         r_speed_gain;
    logic [AGAIN_W-1:0]         r_angle_gain;

    // Captured sample word.
    logic [ENC_W-1:0]           r_enc_now;
    logic [ENC_W-1:0]           r_enc_before;
    logic signed [RPM_W-1:0]    r_rpm;

    // Filter and turn state.
    logic signed [SPEED_W-1:0]  r_newer;
    logic signed [SPEED_W-1:0]  r_older;
    logic signed [TURN_W-1:0]   r_turns;

    // Working registers.
    logic signed [MUL_A_W-1:0]  r_x;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [MUL_B_W-1:0]  r_t;

    // Output register. It holds the whole feedback word, so the next sample
    // can run through the filter while this word still waits.
    logic                       r_out_valid;
    logic signed [SPEED_W-1:0]  r_out_speed;
    logic signed [TURN_W-1:0]   r_out_turns;
    logic signed [ANGLE_W-1:0]  r_out_angle;

    // Shared multiplier.
    logic                       mul_en;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;

    logic                       samp_acc;
    logic                       out_free;
    logic signed [17:0]         enc_diff;
    logic signed [17:0]         jump_thr;
    logic signed [TURN_W:0]     turn_step;
    logic signed [TURN_W-1:0]   n_turns;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [SPEED_W-1:0]  fresh;
    logic signed [PROD_W-1:0]   ang_rnd;
    logic signed [ANGLE_W-1:0]  ang_sat;

    mesfb_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    assign samp_acc     = i_samp.valid && i_samp.ready;
    assign out_free     = !r_out_valid || o_fb.ready;
    assign i_samp.ready = (r_state == ST_IDLE);

    assign o_fb.valid          = r_out_valid;
    assign o_fb.filtered_speed = r_out_speed;
    assign o_fb.turn_count     = r_out_turns;
    assign o_fb.output_angle   = r_out_angle;

    // Turn counting. A jump of exactly the threshold does not count.
    always_comb begin
        enc_diff  = signed'(18'({1'b0, r_enc_now})) - signed'(18'({1'b0, r_enc_before}));
        jump_thr  = signed'(18'(JUMP_THRESHOLD));
        turn_step = signed'((TURN_W + 1)'(r_turns));
        if (enc_diff > jump_thr) begin
            turn_step = turn_step - signed'((TURN_W + 1)'(1));
        end else if (enc_diff < -jump_thr) begin
            turn_step = turn_step + signed'((TURN_W + 1)'(1));
        end
        if (turn_step == signed'((TURN_W + 1)'(TURN_WRAP))) begin
            n_turns = signed'(TURN_W'(1 - TURN_WRAP));
        end else if (turn_step == signed'((TURN_W + 1)'(-TURN_WRAP))) begin
            n_turns = signed'(TURN_W'(TURN_WRAP - 1));
        end else begin
            n_turns = turn_step[TURN_W-1:0];
        end
    end

    // Round half up from Q.16 to an integer and saturate the filter sum.
    always_comb begin
        acc_rnd = (r_acc + signed'(ACC_W'(32768))) >>> 16;
        if (acc_rnd > signed'(ACC_W'(SPEED_MAX))) begin
            fresh = signed'(SPEED_W'(SPEED_MAX));
        end else if (acc_rnd < signed'(ACC_W'(SPEED_MIN))) begin
            fresh = signed'(SPEED_W'(SPEED_MIN));
        end else begin
            fresh = acc_rnd[SPEED_W-1:0];
        end
    end

    // Round half up from Q.16 to an integer and saturate the angle product.
    always_comb begin
        ang_rnd = (prod + signed'(PROD_W'(32768))) >>> 16;
        if (ang_rnd > signed'(PROD_W'(ANGLE_MAX))) begin
            ang_sat = signed'(ANGLE_W'(ANGLE_MAX));
        end else if (ang_rnd < signed'(PROD_W'(ANGLE_MIN))) begin
            ang_sat = signed'(ANGLE_W'(ANGLE_MIN));
        end else begin
            ang_sat = ang_rnd[ANGLE_W-1:0];
        end
    end

    // Operand selection. Each multiplying step issues one product, which the next step uses.
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            ST_RPM: begin
                mul_a = signed'(MUL_A_W'({1'b0, r_speed_gain}));
                mul_b = MUL_B_W'(r_rpm);
            end
            ST_NEWER: begin
                mul_a = C_NEWER;
                mul_b = MUL_B_W'(r_newer);
            end
            ST_OLDER: begin
                mul_a = C_OLDER;
                mul_b = MUL_B_W'(r_older);
            end
            ST_INPUT: begin
                mul_a = r_x;
                mul_b = C_INPUT;
            end
            ST_SPAN: begin
                mul_a = signed'(MUL_A_W'(ENCODER_SPAN));
                mul_b = MUL_B_W'(r_turns);
            end
            ST_ANGLE: begin
                mul_a = signed'(MUL_A_W'({1'b0, r_angle_gain}));
                mul_b = r_t;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (samp_acc) n_state = ST_RPM;
            ST_RPM:   n_state = ST_NEWER;
            ST_NEWER: n_state = ST_OLDER;
            ST_OLDER: n_state = ST_INPUT;
            ST_INPUT: n_state = ST_SPAN;
            ST_SPAN:  n_state = ST_OFFS;
            ST_OFFS:  n_state = ST_ANGLE;
            ST_ANGLE: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state and filter history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_speed_gain <= SGAIN_RST;
            r_angle_gain <= AGAIN_RST;
            r_newer      <= '0;
            r_older      <= '0;
            r_turns      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPEED_GAIN: r_speed_gain <= i_cfg_data[SGAIN_W-1:0];
                    CFG_ANGLE_GAIN: r_angle_gain <= i_cfg_data[AGAIN_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == ST_RPM) begin
                r_turns <= n_turns;
            end
            if (r_state == ST_OFFS) begin
                r_older <= r_newer;
                r_newer <= fresh;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_fb.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (samp_acc) begin
            r_enc_now    <= i_samp.encoder_now;
            r_enc_before <= i_samp.encoder_before;
            r_rpm        <= i_samp.rotor_rpm;
        end
        case (r_state)
            ST_NEWER: r_x   <= MUL_A_W'((prod + signed'(PROD_W'(128))) >>> 8);
            ST_OLDER: r_acc <= prod[ACC_W-1:0];
            ST_INPUT: r_acc <= r_acc + prod[ACC_W-1:0];
            ST_SPAN:  r_acc <= r_acc + prod[ACC_W-1:0];
            ST_OFFS:  r_t   <= prod[MUL_B_W-1:0] + signed'(MUL_B_W'({1'b0, r_enc_now}));
            ST_DONE: begin
                if (out_free) begin
                    r_out_speed <= r_newer;
                    r_out_turns <= r_turns;
                    r_out_angle <= ang_sat;
                end
            end
            default: ;
        endcase
    end

    // An accepted sample always starts the sequence.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        samp_acc |=> r_state == ST_RPM)
        else $error("sample accepted but sequence did not start");

    // The turn count always stays strictly inside the wrap limits.
    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_turns < signed'(TURN_W'(TURN_WRAP))) && (r_turns > signed'(TURN_W'(-TURN_WRAP))))
        else $error("turn count outside wrap range");

    // The filter history shifts by one sample per item.
    a_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OFFS |=> r_older == $past(r_newer))
        else $error("filter history did not shift");

    // A new feedback word only comes from the last sequence step.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("feedback word raised outside the last step");

endmodule
